@@ sv/pccr_pkg.sv @@
// ============================================================================
// pccr_pkg: shared types and constants for point-cloud centering and rotation
// Holds the input and result beat types, register indexes and store sizing.
// ============================================================================
package pccr_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = 38;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHZ   = 3'd6;

    // Rotation axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               last_point;
    } point_in_t;

    typedef struct packed {
        logic signed [31:0] centered_x;
        logic signed [31:0] centered_y;
        logic signed [31:0] centered_z;
        logic signed [31:0] moved_x;
        logic signed [31:0] moved_y;
        logic signed [31:0] moved_z;
        logic               last_result;
        logic               overflowed;
    } point_out_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ sv/point_cloud_center_rotate.sv @@
// ============================================================================
// point_cloud_center_rotate: centroid centering and axis rotation, Q16.16
// Stores a point set, takes its mean, then streams centered and moved points.
// ============================================================================
// Points load at one beat per cycle into three 64-entry synchronous memories
// while the coordinate sums grow. The beat marked last_point starts emission:
// a shared restoring divider forms the three means one after another, one
// quotient bit per cycle, then each stored point goes through a four-stage
// read / center / multiply / combine pipeline and one result beat leaves per
// point, held back only by a stalled result channel.
// No input beat is taken while a set is being divided or emitted.
module point_cloud_center_rotate
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  pccr_pkg::point_in_t                    in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output pccr_pkg::point_out_t                   out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pccr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pccr_pkg::CFG_DATA_W-1:0]        cfg_value
);

    localparam int AW = pccr_pkg::ADDR_W;
    localparam int CW = pccr_pkg::CNT_W;
    localparam int SW = pccr_pkg::SUM_W;
    localparam int DIV_STEPS = SW;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic               mode_reg;
    logic [1:0]         axis_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [31:0] shx_reg;
    logic signed [31:0] shy_reg;
    logic signed [31:0] shz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            axis_reg <= pccr_pkg::AXIS_X;
            cos_reg  <= 16'sd16384;
            sin_reg  <= 16'sd0;
            shx_reg  <= '0;
            shy_reg  <= '0;
            shz_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pccr_pkg::REG_MODE: mode_reg <= cfg_value[0];
                pccr_pkg::REG_AXIS: axis_reg <= cfg_value[1:0];
                pccr_pkg::REG_COS:  cos_reg  <= cfg_value[15:0];
                pccr_pkg::REG_SIN:  sin_reg  <= cfg_value[15:0];
                pccr_pkg::REG_SHX:  shx_reg  <= cfg_value;
                pccr_pkg::REG_SHY:  shy_reg  <= cfg_value;
                pccr_pkg::REG_SHZ:  shz_reg  <= cfg_value;
                default: ;
            endcase
        end
    end

    // Point stores.
    logic [31:0] store_x [pccr_pkg::MAX_POINTS];
    logic [31:0] store_y [pccr_pkg::MAX_POINTS];
    logic [31:0] store_z [pccr_pkg::MAX_POINTS];

    logic signed [SW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [CW-1:0]        count_reg;
    logic                 drop_reg;

    logic in_fire;
    logic has_room;
    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign has_room = (count_reg < CW'(pccr_pkg::MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (in_fire && has_room)
        begin
            store_x[count_reg[AW-1:0]] <= in_data.coord_x;
            store_y[count_reg[AW-1:0]] <= in_data.coord_y;
            store_z[count_reg[AW-1:0]] <= in_data.coord_z;
        end
    end

    // Divider: magnitude restoring division, one bit a cycle.
    logic [1:0]           div_sel_reg;
    logic [5:0]           div_step_reg;
    logic [SW-1:0]        quo_reg;
    logic [CW:0]          rem_reg;
    logic                 neg_reg;
    logic signed [31:0]   mean_x_reg, mean_y_reg, mean_z_reg;
    logic signed [SW-1:0] div_src;
    logic [SW-1:0]        div_mag;
    logic [CW:0]          rem_shift;
    logic [CW:0]          rem_sub;
    logic [SW-1:0]        quo_next;
    logic signed [SW-1:0] quo_signed;

    always_comb
    begin
        case (div_sel_reg)
            2'd0:    div_src = sum_x_reg;
            2'd1:    div_src = sum_y_reg;
            default: div_src = sum_z_reg;
        endcase
        div_mag   = div_src[SW-1] ? SW'(-div_src) : div_src;
        rem_shift = {rem_reg[CW-1:0], quo_reg[SW-1]};
        rem_sub   = rem_shift - {1'b0, count_reg};
        quo_next  = {quo_reg[SW-2:0], ~rem_sub[CW]};
        quo_signed = neg_reg ? SW'(-quo_next) : quo_next;
    end

    // Emission pipeline control.
    logic [CW-1:0] rd_idx_reg;
    logic          rd_done_reg;
    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic          stall;
    logic          issue;

    // Stage registers stall together when the result register is held.
    assign stall = out_valid_reg && !out_ready;
    assign issue = (state_reg == ST_EMIT) && !rd_done_reg && !stall;

    logic [31:0] rd_x_reg, rd_y_reg, rd_z_reg;
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_x_reg <= store_x[rd_idx_reg[AW-1:0]];
            rd_y_reg <= store_y[rd_idx_reg[AW-1:0]];
            rd_z_reg <= store_z[rd_idx_reg[AW-1:0]];
        end
    end

    // Stage 2: center and translate.
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    // Stage 3: products.
    logic signed [48:0] p_ca_reg, p_sb_reg, p_sa_reg, p_cb_reg;
    logic signed [32:0] c3x_reg, c3y_reg, c3z_reg;
    logic signed [31:0] t3x_reg, t3y_reg, t3z_reg;

    logic signed [32:0] rot_a, rot_b;
    always_comb
    begin
        unique case (axis_reg)
            pccr_pkg::AXIS_X: begin rot_a = cy_reg; rot_b = cz_reg; end
            pccr_pkg::AXIS_Y: begin rot_a = cx_reg; rot_b = cz_reg; end
            default:          begin rot_a = cx_reg; rot_b = cy_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            cx_reg <= 33'(signed'(rd_x_reg)) - 33'(mean_x_reg);
            cy_reg <= 33'(signed'(rd_y_reg)) - 33'(mean_y_reg);
            cz_reg <= 33'(signed'(rd_z_reg)) - 33'(mean_z_reg);
            tx_reg <= pccr_pkg::sat32(50'(signed'(rd_x_reg)) + 50'(shx_reg));
            ty_reg <= pccr_pkg::sat32(50'(signed'(rd_y_reg)) + 50'(shy_reg));
            tz_reg <= pccr_pkg::sat32(50'(signed'(rd_z_reg)) + 50'(shz_reg));
            p_ca_reg <= 49'(cos_reg) * 49'(rot_a);
            p_sb_reg <= 49'(sin_reg) * 49'(rot_b);
            p_sa_reg <= 49'(sin_reg) * 49'(rot_a);
            p_cb_reg <= 49'(cos_reg) * 49'(rot_b);
            c3x_reg <= cx_reg;
            c3y_reg <= cy_reg;
            c3z_reg <= cz_reg;
            t3x_reg <= tx_reg;
            t3y_reg <= ty_reg;
            t3z_reg <= tz_reg;
        end
    end

    // Stage 4: combine products, floor shift, saturate.
    logic signed [49:0] sum_first, sum_second;
    logic signed [31:0] rot_first, rot_second;
    always_comb
    begin
        if (axis_reg == pccr_pkg::AXIS_Y)
        begin
            sum_first  = 50'(p_ca_reg) - 50'(p_sb_reg);
            sum_second = 50'(p_sa_reg) + 50'(p_cb_reg);
        end
        else
        begin
            sum_first  = 50'(p_ca_reg) + 50'(p_sb_reg);
            sum_second = 50'(p_cb_reg) - 50'(p_sa_reg);
        end
        rot_first  = pccr_pkg::sat32(sum_first >>> 14);
        rot_second = pccr_pkg::sat32(sum_second >>> 14);
    end

    pccr_pkg::point_out_t res_next;
    always_comb
    begin
        res_next.centered_x  = pccr_pkg::sat32(50'(c3x_reg));
        res_next.centered_y  = pccr_pkg::sat32(50'(c3y_reg));
        res_next.centered_z  = pccr_pkg::sat32(50'(c3z_reg));
        res_next.moved_x     = res_next.centered_x;
        res_next.moved_y     = res_next.centered_y;
        res_next.moved_z     = res_next.centered_z;
        res_next.last_result = s3_last_reg;
        res_next.overflowed  = ovf_reg;
        if (!mode_reg)
        begin
            res_next.moved_x = t3x_reg;
            res_next.moved_y = t3y_reg;
            res_next.moved_z = t3z_reg;
        end
        else
        begin
            case (axis_reg)
                pccr_pkg::AXIS_X:
                begin
                    res_next.moved_y = rot_first;
                    res_next.moved_z = rot_second;
                end
                pccr_pkg::AXIS_Y:
                begin
                    res_next.moved_x = rot_first;
                    res_next.moved_z = rot_second;
                end
                pccr_pkg::AXIS_Z:
                begin
                    res_next.moved_x = rot_first;
                    res_next.moved_y = rot_second;
                end
                default: ;
            endcase
        end
    end

    pccr_pkg::point_out_t out_data_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (!stall && s3_valid_reg)
        begin
            out_data_reg <= res_next;
        end
    end

    // Control: state, sums, divider and pipeline valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            div_sel_reg   <= '0;
            div_step_reg  <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            mean_x_reg    <= '0;
            mean_y_reg    <= '0;
            mean_z_reg    <= '0;
            rd_idx_reg    <= '0;
            rd_done_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_last_reg   <= 1'b0;
            s3_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (has_room)
                        begin
                            sum_x_reg <= sum_x_reg + SW'(in_data.coord_x);
                            sum_y_reg <= sum_y_reg + SW'(in_data.coord_y);
                            sum_z_reg <= sum_z_reg + SW'(in_data.coord_z);
                            count_reg <= count_reg + 1'b1;
                        end
                        if (in_data.last_point)
                        begin
                            ovf_reg      <= drop_reg || !has_room;
                            drop_reg     <= 1'b0;
                            div_sel_reg  <= 2'd0;
                            div_step_reg <= '0;
                            state_reg    <= ST_DIV;
                        end
                        else if (!has_room)
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    // Step zero loads the magnitude; later steps shift.
                    if (div_step_reg == 6'd0)
                    begin
                        quo_reg      <= div_mag;
                        rem_reg      <= '0;
                        neg_reg      <= div_src[SW-1];
                        div_step_reg <= 6'd1;
                    end
                    else
                    begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_sub[CW] ? rem_shift : rem_sub;
                        if (div_step_reg == 6'(DIV_STEPS))
                        begin
                            div_step_reg <= '0;
                            unique case (div_sel_reg)
                                2'd0: mean_x_reg <= quo_signed[31:0];
                                2'd1: mean_y_reg <= quo_signed[31:0];
                                default: mean_z_reg <= quo_signed[31:0];
                            endcase
                            if (div_sel_reg == 2'd2)
                            begin
                                rd_idx_reg  <= '0;
                                rd_done_reg <= 1'b0;
                                state_reg   <= ST_EMIT;
                            end
                            else
                            begin
                                div_sel_reg <= div_sel_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            div_step_reg <= div_step_reg + 6'd1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!stall)
                    begin
                        s1_valid_reg <= issue;
                        s1_last_reg  <= issue && (rd_idx_reg + 1'b1 == count_reg);
                        s2_valid_reg <= s1_valid_reg;
                        s2_last_reg  <= s1_last_reg;
                        s3_valid_reg <= s2_valid_reg;
                        s3_last_reg  <= s2_last_reg;
                        out_valid_reg <= s3_valid_reg;
                        if (issue)
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                            if (rd_idx_reg + 1'b1 == count_reg)
                            begin
                                rd_done_reg <= 1'b1;
                            end
                        end
                    end
                    // The final beat leaving closes the set. Nothing is behind
                    // it, so the result register empties on the same edge.
                    if (out_valid_reg && out_ready && out_data_reg.last_result)
                    begin
                        sum_x_reg     <= '0;
                        sum_y_reg     <= '0;
                        sum_z_reg     <= '0;
                        count_reg     <= '0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

@@ bench/tb.sv @@
// ============================================================================
// tb: self-checking bench for point_cloud_center_rotate
// Loads point sets through the input channel, predicts every centered and
// moved result from a local model of the centering and rotation math, and
// compares each result beat field by field under random idling on both sides.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int MODE_TRANSLATE = 0;
    localparam int MODE_ROTATE    = 1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pccr_pkg::point_in_t   in_data;
    logic        out_valid;
    logic        out_ready;
    pccr_pkg::point_out_t  out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [pccr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pccr_pkg::CFG_DATA_W-1:0] cfg_value;

    point_cloud_center_rotate u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_value (cfg_value)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Local copy of the configuration and of the point set being loaded.
    logic        m_mode;
    logic [1:0]  m_axis;
    logic signed [15:0] m_cos;
    logic signed [15:0] m_sin;
    logic signed [31:0] m_shx, m_shy, m_shz;
    logic signed [31:0] set_x[pccr_pkg::MAX_POINTS];
    logic signed [31:0] set_y[pccr_pkg::MAX_POINTS];
    logic signed [31:0] set_z[pccr_pkg::MAX_POINTS];
    logic signed [63:0] acc_x, acc_y, acc_z;
    int          set_count;
    logic        set_dropped;

    pccr_pkg::point_out_t  pending_results[$];
    int          mismatches;
    int          results_seen;
    int          sets_done;
    int          idle_cycles;
    logic        hold_off;
    logic        stim_done;
    int          rx_gap;
    int          rx_seen = 0;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Weighted pair, floor shift by 14, then saturate.
    function automatic logic signed [31:0] rot_term(input logic signed [63:0] ca,
                                                    input logic signed [63:0] a,
                                                    input logic signed [63:0] cb,
                                                    input logic signed [63:0] b);
        logic signed [63:0] acc;
        acc = ca * a + cb * b;
        return clip32(acc >>> 14);
    endfunction

    function automatic void apply_reg(input int idx, input logic [31:0] val);
        case (idx)
            pccr_pkg::REG_MODE: m_mode = val[0];
            pccr_pkg::REG_AXIS: m_axis = val[1:0];
            pccr_pkg::REG_COS:  m_cos  = val[15:0];
            pccr_pkg::REG_SIN:  m_sin  = val[15:0];
            pccr_pkg::REG_SHX:  m_shx  = val;
            pccr_pkg::REG_SHY:  m_shy  = val;
            pccr_pkg::REG_SHZ:  m_shz  = val;
            default: ;
        endcase
    endfunction

    // Accumulate one accepted point and, on the last one, queue the set's results.
    function automatic void predict_centering(input pccr_pkg::point_in_t p);
        logic signed [63:0] mx, my, mz, cx, cy, cz, c, s;
        pccr_pkg::point_out_t r;
        if (set_count < pccr_pkg::MAX_POINTS)
        begin
            set_x[set_count] = p.coord_x;
            set_y[set_count] = p.coord_y;
            set_z[set_count] = p.coord_z;
            acc_x += p.coord_x;
            acc_y += p.coord_y;
            acc_z += p.coord_z;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (!p.last_point || set_count == 0)
        begin
            return;
        end
        mx = acc_x / set_count;
        my = acc_y / set_count;
        mz = acc_z / set_count;
        c = m_cos;
        s = m_sin;
        for (int k = 0; k < set_count; k++)
        begin
            cx = set_x[k] - mx;
            cy = set_y[k] - my;
            cz = set_z[k] - mz;
            r.centered_x = clip32(cx);
            r.centered_y = clip32(cy);
            r.centered_z = clip32(cz);
            if (m_mode == MODE_TRANSLATE)
            begin
                r.moved_x = clip32(64'(set_x[k]) + m_shx);
                r.moved_y = clip32(64'(set_y[k]) + m_shy);
                r.moved_z = clip32(64'(set_z[k]) + m_shz);
            end
            else if (m_axis == pccr_pkg::AXIS_X)
            begin
                r.moved_x = clip32(cx);
                r.moved_y = rot_term(c, cy, s, cz);
                r.moved_z = rot_term(-s, cy, c, cz);
            end
            else if (m_axis == pccr_pkg::AXIS_Y)
            begin
                r.moved_x = rot_term(c, cx, -s, cz);
                r.moved_y = clip32(cy);
                r.moved_z = rot_term(s, cx, c, cz);
            end
            else if (m_axis == pccr_pkg::AXIS_Z)
            begin
                r.moved_x = rot_term(c, cx, s, cy);
                r.moved_y = rot_term(-s, cx, c, cy);
                r.moved_z = clip32(cz);
            end
            else
            begin
                r.moved_x = clip32(cx);
                r.moved_y = clip32(cy);
                r.moved_z = clip32(cz);
            end
            r.last_result = (k == set_count - 1);
            r.overflowed  = set_dropped;
            pending_results.push_back(r);
        end
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        set_count = 0;
        set_dropped = 1'b0;
        sets_done++;
    endfunction

    // Write one register through the configuration channel.
    task automatic write_reg(input int idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[pccr_pkg::CFG_IDX_W-1:0];
        cfg_value <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one point beat after a random gap.
    task automatic send_point(input pccr_pkg::point_in_t p);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_centering(p);
    endtask

    // Wait until all results are back, then let the pipeline drain.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int n, input bit bad_end);
        pccr_pkg::point_in_t p;
        for (int i = 0; i < n; i++)
        begin
            p.coord_x = rand_coord();
            p.coord_y = rand_coord();
            p.coord_z = rand_coord();
            p.last_point = (i == n - 1) && !bad_end;
            send_point(p);
        end
    endtask

    // Receiver: after each accepted beat it draws a random wait, and it holds
    // off entirely while a long stall is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap = $urandom_range(0, 7);
        end
        else
        begin
            if (results_seen != rx_seen)
            begin
                rx_seen = results_seen;
                rx_gap  = $urandom_range(0, 7);
            end
            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                out_ready <= 1'b0;
                rx_gap = rx_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        pccr_pkg::point_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat %p", out_data);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected %p", want);
                        $display("                 actual   %p", out_data);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (!stim_done || pending_results.size() != 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Directed rows: point data, last flag, and an optional typed expectation.
    typedef struct {
        logic signed [31:0] x, y, z;
        logic               last;
        logic               typed;
        pccr_pkg::point_out_t want;
    } dir_row_t;

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        pccr_pkg::point_in_t p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_value = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        mismatches = 0;
        results_seen = 0;
        sets_done = 0;
        idle_cycles = 0;
        m_mode = 1'b0;
        m_axis = '0;
        m_cos = 16'sd16384;
        m_sin = '0;
        m_shx = '0;
        m_shy = '0;
        m_shz = '0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        set_count = 0;
        set_dropped = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: single points echo themselves.
        row = '{x: 32'sh7FFFFFFF, y: 32'sh80000000, z: 0, last: 1, typed: 1,
                want: '{0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{x: 5, y: -5, z: 7, last: 1, typed: 1,
                want: '{0, 0, 0, 5, -5, 7, 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{x: 32'sh7FFFFFFF, y: 32'sh80000000, z: 3, last: 0, typed: 0, want: '0};
        rows.push_back(row);
        row = '{x: 32'sh80000000, y: 32'sh7FFFFFFF, z: -4, last: 1, typed: 0, want: '0};
        rows.push_back(row);
        row = '{x: 1, y: 2, z: 3, last: 0, typed: 0, want: '0};
        rows.push_back(row);
        row = '{x: -1, y: -2, z: -4, last: 1, typed: 0, want: '0};
        rows.push_back(row);
        foreach (rows[i])
        begin
            p.coord_x = rows[i].x;
            p.coord_y = rows[i].y;
            p.coord_z = rows[i].z;
            p.last_point = rows[i].last;
            send_point(p);
            if (rows[i].typed && pending_results.size() != 0
                && pending_results[pending_results.size() - 1] !== rows[i].want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("directed row %0d expected %p", i, rows[i].want);
                    $display("              predicted %p",
                             pending_results[pending_results.size() - 1]);
                end
            end
        end
        wait_drained();

        // Translate with extreme shifts, then rotations about each axis.
        write_reg(pccr_pkg::REG_SHX, 32'h7FFFFFFF);
        write_reg(pccr_pkg::REG_SHY, 32'h80000000);
        write_reg(pccr_pkg::REG_SHZ, 32'h00010000);
        send_random_set(3, 0);
        wait_drained();
        write_reg(pccr_pkg::REG_MODE, MODE_ROTATE);
        for (int a = 0; a < 4; a++)
        begin
            write_reg(pccr_pkg::REG_AXIS, a);
            write_reg(pccr_pkg::REG_COS, (a == 1) ? 32'h0000C000 : 32'h00002D41);
            write_reg(pccr_pkg::REG_SIN, (a == 2) ? 32'h00004000 : 32'h0000D2BF);
            send_random_set(2, 0);
            wait_drained();
        end

        // Capacity overflow with long receiver hold-off; last point is dropped.
        // The next set is offered while the block is still emitting, so its
        // first point waits at a stalled input.
        fork
        begin
            hold_off = 1'b1;
            repeat (1000) @(posedge clk);
            hold_off = 1'b0;
        end
        begin
            send_random_set(pccr_pkg::MAX_POINTS + 2, 0);
            send_random_set(4, 0);
        end
        join
        wait_drained();
        // A full set that drops nothing, so the flag is seen cleared.
        send_random_set(pccr_pkg::MAX_POINTS, 0);
        wait_drained();

        // Random part: mostly small sets, occasional reconfiguration.
        for (int n_sent = 0; n_sent < 150; )
        begin
            int n;
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 6), $urandom);
                if ($urandom_range(0, 1) == 0)
                begin
                    write_reg(pccr_pkg::REG_COS, $urandom_range(0, 32768) - 16384);
                end
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_random_set(n, 0);
            n_sent += n;
            wait_drained();
        end
        write_reg(pccr_pkg::REG_MODE, MODE_TRANSLATE);
        write_reg(pccr_pkg::REG_COS, 32'h00004000);
        write_reg(pccr_pkg::REG_SIN, 32'h0000C000);
        send_random_set(5, 0);
        wait_drained();
        stim_done = 1'b1;

        $display("Covered %0d point sets, %0d result beats, both modes, all axis codes,",
                 sets_done, results_seen);
        $display("capacity overflow and a long output hold-off.");
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
